>>> rtl/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg: shared types and constants
// Opcodes, the queued command record and the statistics entry record.
// ----------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

    localparam logic [1:0] OP_COLLECT = 2'd0;
    localparam logic [1:0] OP_CHECK   = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;
    localparam logic [63:0] ALL_ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;

    // command handed from the front end to the back end
    typedef struct packed {
        logic [1:0]  op;
        logic        bad;
        logic [31:0] dur;
        logic [63:0] start;
        logic [15:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum;
        logic [31:0] min;
        logic [31:0] max;
        logic [63:0] max_start;
        logic [31:0] warnings;
    } t_entry;

    typedef struct packed {
        logic [63:0] start_time;
        logic        over_warning;
        logic        index_error;
        logic [31:0] hit_count;
        logic [31:0] min_duration;
        logic [31:0] avg_duration;
        logic [31:0] max_duration;
        logic [63:0] max_start_time;
        logic [31:0] warning_line;
        logic [31:0] warning_count;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/per_id_latency_stats_table_core.sv
// Sequence: collect runs the radix-2 divider once, for the reported average
//   after the table write-back; check and read run it for the warning line
//   and again for the reported average; a bad index runs no divide.
// Throughput: one item at a time in the back end; the two-entry queue takes
//   up to two more items meanwhile.
// Reset: synchronous, active low; then the back end clears every table entry.
// ----------------------------------------------------------------------------
// per_id_latency_stats_table_core: per-name latency statistics table
// Front end rebuilds start times, back end keeps count, sum, min, max, max
// start and warning count per entry in a single-port table.
// ----------------------------------------------------------------------------
`default_nettype none

module per_id_latency_stats_table_core #(
    parameter int IDX_W = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic        i_new_file,
    input  wire logic [31:0] i_end_delta,
    input  wire logic [31:0] i_duration,
    input  wire logic [9:0]  i_entry_index,
    // result items
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_start_time,
    output logic             o_over_warning,
    output logic             o_index_error,
    output logic [31:0]      o_hit_count,
    output logic [31:0]      o_min_duration,
    output logic [31:0]      o_avg_duration,
    output logic [31:0]      o_max_duration,
    output logic [63:0]      o_max_start_time,
    output logic [31:0]      o_warning_line,
    output logic [31:0]      o_warning_count,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import plst_pkg::*;

    localparam logic [1:0] ADDR_NAME_COUNT = 2'd0;

    logic [10:0] r_name_count;
    logic        w_cmd_valid;
    logic        w_cmd_ready;
    t_cmd        w_cmd;
    logic        w_q_valid;
    logic        w_q_ready;
    t_cmd        w_q_cmd;
    t_result     w_res;

    // hold name_count; write on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NAME_COUNT) ? {21'd0, r_name_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_count <= 11'd1024;
        end else if (psel && penable && pwrite && paddr == ADDR_NAME_COUNT) begin
            r_name_count <= pwdata[10:0];
        end
    end

    plst_front #(.IDX_W(IDX_W)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_new_file   (i_new_file),
        .i_end_delta  (i_end_delta),
        .i_duration   (i_duration),
        .i_entry_index(i_entry_index),
        .i_name_count (r_name_count),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    plst_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_cmd_valid),
        .o_ready(w_cmd_ready),
        .i_cmd  (w_cmd),
        .o_valid(w_q_valid),
        .i_ready(w_q_ready),
        .o_cmd  (w_q_cmd)
    );

    plst_back #(.IDX_W(IDX_W)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_q_valid),
        .o_ready(w_q_ready),
        .i_cmd  (w_q_cmd),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_res  (w_res)
    );

    assign o_start_time     = w_res.start_time;
    assign o_over_warning   = w_res.over_warning;
    assign o_index_error    = w_res.index_error;
    assign o_hit_count      = w_res.hit_count;
    assign o_min_duration   = w_res.min_duration;
    assign o_avg_duration   = w_res.avg_duration;
    assign o_max_duration   = w_res.max_duration;
    assign o_max_start_time = w_res.max_start_time;
    assign o_warning_line   = w_res.warning_line;
    assign o_warning_count  = w_res.warning_count;

endmodule

`default_nettype wire

>>> rtl/plst_front.sv
// ----------------------------------------------------------------------------
// plst_front: record intake
// Rebuilds start times from the running end timestamp, checks the index.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_front #(
    parameter int IDX_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_opcode,
    input  wire logic             i_new_file,
    input  wire logic [31:0]      i_end_delta,
    input  wire logic [31:0]      i_duration,
    input  wire logic [9:0]       i_entry_index,
    input  wire logic [10:0]      i_name_count,
    output logic                  o_cmd_valid,
    input  wire logic             i_cmd_ready,
    output plst_pkg::t_cmd        o_cmd
);
    import plst_pkg::*;

    localparam int ENTRIES = 1 << IDX_W;

    logic [63:0] r_end_time;
    logic [63:0] w_end;
    logic        w_rec;
    logic        w_bad;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign w_rec = (i_opcode == OP_COLLECT) || (i_opcode == OP_CHECK);
    assign w_end = (i_new_file ? 64'd0 : r_end_time) + {32'd0, i_end_delta};
    assign w_bad = ({6'd0, i_entry_index} >= {5'd0, i_name_count}) ||
                   ({22'd0, i_entry_index} >= 32'(ENTRIES));

    always_comb begin
        o_cmd.op    = w_rec ? i_opcode : OP_READ;
        o_cmd.bad   = w_bad;
        o_cmd.dur   = i_duration;
        o_cmd.start = w_rec ? (w_end - {32'd0, i_duration}) : 64'd0;
        o_cmd.idx   = {6'd0, i_entry_index};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_time <= 64'd0;
        end else if (i_valid && i_cmd_ready && w_rec) begin
            r_end_time <= w_end;
        end
    end

endmodule

`default_nettype wire

>>> rtl/plst_queue.sv
// ----------------------------------------------------------------------------
// plst_queue: two-entry command queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  plst_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  wire logic      i_ready,
    output plst_pkg::t_cmd o_cmd
);
    import plst_pkg::*;

    t_cmd r_mem [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;
    logic w_push;
    logic w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

`default_nettype wire

>>> rtl/plst_div.sv
// ----------------------------------------------------------------------------
// plst_div: radix-2 divider
// Divides 64 bits by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;
    logic        w_ge;

    assign w_sh   = {r_rem[31:0], r_q[63]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= i_num;
                r_rem  <= 33'd0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/plst_back.sv
// ----------------------------------------------------------------------------
// plst_back: statistics engine
// Clears the table; per valid index: read, update, write unless a read, divide.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_back #(
    parameter int IDX_W = 10
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  plst_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  wire logic         i_ready,
    output plst_pkg::t_result o_res
);
    import plst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_DIV, S_UPD, S_DIV2, S_OUT
    } t_state;

    localparam int DEPTH = 1 << IDX_W;

    t_entry r_mem [DEPTH];
    t_state r_state;
    t_cmd   r_cmd;
    t_entry r_ent;
    logic [IDX_W-1:0] r_clr;
    logic        r_div_start;
    logic        w_div_done;
    logic [63:0] w_quot;
    logic [31:0] w_avg;
    logic [31:0] w_line;
    logic [64:0] w_sum;
    logic [32:0] w_ls;

    plst_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (r_ent.sum),
        .i_den  (r_ent.count),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign o_ready = (r_state == S_IDLE);
    assign w_avg   = (r_ent.count == 32'd0) ? 32'd0 :
                     ((w_quot[63:32] != 32'd0) ? ALL_ONES_32 : w_quot[31:0]);
    assign w_ls    = {1'b0, w_avg} + {1'b0, r_ent.max};
    assign w_line  = (r_ent.count == 32'd0) ? 32'd0 : w_ls[32:1];
    assign w_sum   = {1'b0, r_ent.sum} + {33'd0, r_cmd.dur};

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr] <= '{count: 32'd0, sum: 64'd0, min: ALL_ONES_32,
                              max: 32'd0, max_start: 64'd0, warnings: 32'd0};
        end else if (r_state == S_UPD && !r_cmd.bad && r_cmd.op != OP_READ) begin
            r_mem[r_cmd.idx[IDX_W-1:0]] <= r_ent;
        end
        if (r_state == S_IDLE) begin
            r_ent <= r_mem[i_cmd.idx[IDX_W-1:0]];
        end
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            o_valid     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // collect updates first, check and read divide first
                    if (r_cmd.bad) begin
                        r_state <= S_UPD;
                    end else if (r_cmd.op == OP_COLLECT) begin
                        if (r_ent.count != ALL_ONES_32) r_ent.count <= r_ent.count + 32'd1;
                        r_ent.sum <= w_sum[64] ? ALL_ONES_64 : w_sum[63:0];
                        if (r_ent.max < r_cmd.dur) begin
                            r_ent.max       <= r_cmd.dur;
                            r_ent.max_start <= r_cmd.start;
                        end
                        if (r_ent.min > r_cmd.dur) r_ent.min <= r_cmd.dur;
                        r_state <= S_UPD;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        o_res.over_warning <= 1'b0;
                        if (r_cmd.op == OP_CHECK && r_cmd.dur >= w_line) begin
                            o_res.over_warning <= 1'b1;
                            if (r_ent.warnings != ALL_ONES_32)
                                r_ent.warnings <= r_ent.warnings + 32'd1;
                        end
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_cmd.bad) begin
                        r_state <= S_OUT;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV2;
                    end
                    if (r_cmd.op != OP_CHECK || r_cmd.bad) o_res.over_warning <= 1'b0;
                end
                S_DIV2: begin
                    if (w_div_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid                <= 1'b1;
                        o_res.start_time       <= r_cmd.start;
                        o_res.index_error      <= r_cmd.bad;
                        o_res.hit_count        <= r_cmd.bad ? 32'd0 : r_ent.count;
                        o_res.min_duration     <= r_cmd.bad ? 32'd0 : r_ent.min;
                        o_res.avg_duration     <= r_cmd.bad ? 32'd0 : w_avg;
                        o_res.max_duration     <= r_cmd.bad ? 32'd0 : r_ent.max;
                        o_res.max_start_time   <= r_cmd.bad ? 64'd0 : r_ent.max_start;
                        o_res.warning_line     <= r_cmd.bad ? 32'd0 : w_line;
                        o_res.warning_count    <= r_cmd.bad ? 32'd0 : r_ent.warnings;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/plst_checker.sv
// ----------------------------------------------------------------------------
// plst_checker: port-level checks
// Watches the result channel and the error flag of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_index_error,
    input wire logic        o_over_warning,
    input wire logic [31:0] o_hit_count,
    input wire logic [31:0] o_warning_line,
    input wire logic [63:0] o_start_time
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_start_time))
        else $error("result dropped while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_error |-> o_hit_count == 32'd0 && !o_over_warning)
        else $error("error result carries stats");

    a_empty_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit_count == 32'd0 |-> o_warning_line == 32'd0)
        else $error("warning line of empty entry not zero");

endmodule

bind per_id_latency_stats_table_core plst_checker u_plst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_index_error (o_index_error),
    .o_over_warning(o_over_warning),
    .o_hit_count   (o_hit_count),
    .o_warning_line(o_warning_line),
    .o_start_time  (o_start_time)
);

`default_nettype wire
